/* rtl/pdh_pkg.sv */
package pdh_pkg;

  localparam logic [1:0] REQ_ACCUM    = 2'd0;
  localparam logic [1:0] REQ_SNAPSHOT = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;

  localparam logic CFG_INV_WIDTH = 1'b0;
  localparam logic CFG_BIN_LIMIT = 1'b1;

  localparam logic [15:0] INV_WIDTH_RESET = 16'd2560;
  localparam logic [8:0]  BIN_LIMIT_RESET = 9'd100;

  localparam int FRAC_SHIFT = 24;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_SCALE = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_RDATA = 4'd7;

  typedef logic [3:0] state_t;

endpackage

/* rtl/pdh_isqrt.sv */
module pdh_isqrt #(
  parameter int W = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] op,
  output logic           done,
  output logic [W-1:0]   root
);

  localparam int CW = $clog2(W + 1);

  logic           active;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] opr;
  logic [W+1:0]   rem;
  logic [W+1:0]   rem_sh;
  logic [W+1:0]   trial;

  assign rem_sh = {rem[W-1:0], opr[2*W-1:2*W-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        opr    <= op;
        rem    <= '0;
        root   <= '0;
      end else if (active) begin
        opr <= {opr[2*W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/pdh_hist_ram.sv */
module pdh_hist_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pair_distance_histogram.sv */
// Accumulate runs S_MUL, S_SUM, S_ROOT, S_SCALE, then S_LOAD for an in-range bin; a read
// waits in S_RDATA while the last result is stalled. One item at a time; accumulate set by the
// bit-serial square root (one root bit per cycle), snapshot one per cycle while idle
// reset: rst synchronous; clears control, count and registers, then a clearing pass
// writes zero to all NUM_SPECIES*NUM_SPECIES*MAX_BINS histogram entries, one per
// cycle, with in_stall high
module pair_distance_histogram #(
  parameter int NUM_SPECIES = 4,
  parameter int MAX_BINS    = 256,
  parameter int COORD_BITS  = 24,
  parameter int COUNT_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   req_type,
  input  logic [1:0]                   species_a,
  input  logic [1:0]                   species_b,
  input  logic signed [COORD_BITS-1:0] dx,
  input  logic signed [COORD_BITS-1:0] dy,
  input  logic signed [COORD_BITS-1:0] dz,
  input  logic [7:0]                   read_bin,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  bin_value,
  output logic [31:0]                  snapshot_count
);

  localparam int DEPTH = NUM_SPECIES * NUM_SPECIES * MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CB    = COORD_BITS;
  localparam int PW    = CB + 16;
  localparam int XW    = PW + 1;

  pdh_pkg::state_t state;

  logic [15:0]           inv_bin_width;
  logic [8:0]            bin_limit;
  logic [COUNT_BITS-1:0] sample_total;

  logic [CB-1:0]   mag_x, mag_y, mag_z;
  logic [2*CB-1:0] sq_x, sq_y, sq_z;
  logic [2*CB-1:0] sum_sq;
  logic [PW-1:0]   prod;
  logic [AW-1:0]   pair_base;
  logic [AW-1:0]   addr;
  logic            rd_zero;
  logic [AW-1:0]   clr_addr;

  logic            sqrt_start;
  logic            sqrt_done;
  logic [CB-1:0]   root;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  logic            sp_ok;
  logic [AW-1:0]   in_base;
  logic [XW-1:0]   bin_full;
  logic [XW-1:0]   limit;
  logic            bin_ok;
  logic [AW-1:0]   bin_addr;
  logic            rd_ok;
  logic            accept;
  logic            out_free;

  assign in_stall = (state != pdh_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign sp_ok   = (32'(species_a) < NUM_SPECIES) && (32'(species_b) < NUM_SPECIES);
  assign in_base = AW'((32'(species_a) * NUM_SPECIES + 32'(species_b)) * MAX_BINS);
  assign rd_ok   = sp_ok && (32'(read_bin) < MAX_BINS);

  assign bin_full = (XW'(prod) + (XW'(1) << (pdh_pkg::FRAC_SHIFT - 1)))
                    >> pdh_pkg::FRAC_SHIFT;
  assign limit    = (32'(bin_limit) < MAX_BINS) ? XW'(bin_limit) : XW'(MAX_BINS);
  assign bin_ok   = bin_full < limit;
  assign bin_addr = pair_base + AW'(bin_full);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr;
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
    unique case (state)
      pdh_pkg::S_IDLE: begin
        mem_re    = accept && (req_type == pdh_pkg::REQ_READ) && rd_ok;
        mem_raddr = in_base + AW'(read_bin);
      end
      pdh_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      pdh_pkg::S_SCALE: begin
        mem_re    = bin_ok;
        mem_raddr = bin_addr;
      end
      pdh_pkg::S_LOAD: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sqrt_start = (state == pdh_pkg::S_SUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pdh_pkg::S_CLEAR;
      clr_addr      <= '0;
      inv_bin_width <= pdh_pkg::INV_WIDTH_RESET;
      bin_limit     <= pdh_pkg::BIN_LIMIT_RESET;
      sample_total  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pdh_pkg::CFG_INV_WIDTH: inv_bin_width <= cfg_data;
          pdh_pkg::CFG_BIN_LIMIT: bin_limit     <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall && (state != pdh_pkg::S_RDATA)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pdh_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= pdh_pkg::S_IDLE;
          end
        end
        pdh_pkg::S_IDLE: begin
          if (accept) begin
            unique case (req_type)
              pdh_pkg::REQ_ACCUM: begin
                if (sp_ok) begin
                  mag_x     <= dx[CB-1] ? CB'(-dx) : CB'(dx);
                  mag_y     <= dy[CB-1] ? CB'(-dy) : CB'(dy);
                  mag_z     <= dz[CB-1] ? CB'(-dz) : CB'(dz);
                  pair_base <= in_base;
                  state     <= pdh_pkg::S_MUL;
                end
              end
              pdh_pkg::REQ_SNAPSHOT: begin
                if (sample_total != '1) begin
                  sample_total <= sample_total + 1'b1;
                end
              end
              pdh_pkg::REQ_READ: begin
                rd_zero <= !rd_ok;
                state   <= pdh_pkg::S_RDATA;
              end
              default: begin
              end
            endcase
          end
        end
        pdh_pkg::S_MUL: begin
          sq_x  <= mag_x * mag_x;
          sq_y  <= mag_y * mag_y;
          sq_z  <= mag_z * mag_z;
          state <= pdh_pkg::S_SUM;
        end
        pdh_pkg::S_SUM: begin
          state <= pdh_pkg::S_ROOT;
        end
        pdh_pkg::S_ROOT: begin
          if (sqrt_done) begin
            prod  <= PW'(root) * PW'(inv_bin_width);
            state <= pdh_pkg::S_SCALE;
          end
        end
        pdh_pkg::S_SCALE: begin
          addr  <= bin_addr;
          state <= bin_ok ? pdh_pkg::S_LOAD : pdh_pkg::S_IDLE;
        end
        pdh_pkg::S_LOAD: begin
          state <= pdh_pkg::S_IDLE;
        end
        pdh_pkg::S_RDATA: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            bin_value      <= rd_zero ? 32'd0 : 32'(mem_rdata);
            snapshot_count <= 32'(sample_total);
            state          <= pdh_pkg::S_IDLE;
          end
        end
        default: begin
          state <= pdh_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign sum_sq = sq_x + sq_y + sq_z;

  pdh_isqrt #(
    .W (CB)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .op    (sum_sq),
    .done  (sqrt_done),
    .root  (root)
  );

  pdh_hist_ram #(
    .DEPTH (DEPTH),
    .DW    (COUNT_BITS)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  a_load_after_scale: assert property (@(posedge clk) disable iff (rst)
    (state == pdh_pkg::S_LOAD) |-> ($past(state) == pdh_pkg::S_SCALE))
    else $error("histogram write without a preceding bin read");

  a_snap_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (sample_total >= $past(sample_total)))
    else $error("snapshot count decreased");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == pdh_pkg::S_RDATA))
    else $error("result beat not caused by a read");
`endif

endmodule
